>>> rtl/chc_pkg.sv
// Package: widths, constants, arctangent table and the CORDIC vector type.
package chc_pkg;

    localparam int AXIS_W         = 12;
    localparam int DECL_W         = 15;
    localparam int HEAD_W         = 15;
    localparam int PRE_SHIFT      = 12;
    localparam int VEC_W          = 27;
    localparam int ACC_W          = 26;
    localparam int TOT_W          = 28;
    localparam int UNIT_SHIFT     = 10;
    localparam int QUO_W          = 17;
    localparam int TABLE_LEN      = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic signed [DECL_W-1:0] DECL_RESET   = DECL_W'(284);
    localparam logic signed [ACC_W-1:0]  ANGLE_90     = ACC_W'(90 * 65536);
    localparam logic [QUO_W-1:0]         FULL_TURN    = QUO_W'(23040);
    localparam logic [QUO_W-1:0]         TWO_TURNS    = QUO_W'(2 * 23040);
    localparam logic signed [TOT_W-1:0]  BIAS_ROUND   = TOT_W'(2 * 23040 * 1024 + 512);

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ACC_W-1:0] acc;
        logic                    zero;
    } chc_vec_t;

    function automatic logic signed [ACC_W-1:0] chc_atan(input int idx);
        logic signed [ACC_W-1:0] r;
        begin
            unique case (idx)
                0:  r = ACC_W'(2949120);
                1:  r = ACC_W'(1740967);
                2:  r = ACC_W'(919879);
                3:  r = ACC_W'(466945);
                4:  r = ACC_W'(234379);
                5:  r = ACC_W'(117304);
                6:  r = ACC_W'(58666);
                7:  r = ACC_W'(29335);
                8:  r = ACC_W'(14668);
                9:  r = ACC_W'(7334);
                10: r = ACC_W'(3667);
                11: r = ACC_W'(1833);
                12: r = ACC_W'(917);
                13: r = ACC_W'(458);
                14: r = ACC_W'(229);
                15: r = ACC_W'(115);
                16: r = ACC_W'(57);
                17: r = ACC_W'(29);
                18: r = ACC_W'(14);
                19: r = ACC_W'(7);
                20: r = ACC_W'(4);
                21: r = ACC_W'(2);
                22: r = ACC_W'(1);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> rtl/chc_sample_if.sv
// Interface: magnetometer sample channel.
interface chc_sample_if;
    import chc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [AXIS_W-1:0] x_axis;
    logic signed [AXIS_W-1:0] y_axis;

    modport source (output valid, output x_axis, output y_axis, input ready);
    modport sink   (input valid, input x_axis, input y_axis, output ready);
endinterface

>>> rtl/chc_heading_if.sv
// Interface: heading result channel.
interface chc_heading_if;
    import chc_pkg::*;

    logic              valid;
    logic              ready;
    logic [HEAD_W-1:0] heading;

    modport source (output valid, output heading, input ready);
    modport sink   (input valid, input heading, output ready);
endinterface

>>> rtl/compass_heading_from_xy.sv
// Top level: pipelined CORDIC compass heading with declination correction.
// Registers from sample transaction to result valid: pre-rotation, each CORDIC stage, sum, output.
// Throughput: one transaction per cycle; each stage holds its own valid bit,
// so bubbles close up and a stalled output blocks input only when all stages are full.
// Reset: asynchronous active-low; clears all valid bits, declination returns to 284.
module compass_heading_from_xy #(
    parameter int CORDIC_STAGES = chc_pkg::CORDIC_STAGES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic signed [chc_pkg::DECL_W-1:0] cfg_wr_data,
    chc_sample_if.sink                       sample,
    chc_heading_if.source                    result
);
    import chc_pkg::*;

    localparam int N = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

    logic signed [DECL_W-1:0] decl_reg;

    logic                     pre_v_reg;
    chc_vec_t                 pre_reg;
    chc_vec_t                 pre_next;
    logic                     pre_ready;

    logic                     stg_valid [0:N];
    logic                     stg_ready [0:N];
    chc_vec_t                 stg_vec   [0:N];

    logic                     sum_v_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic [QUO_W-1:0]         quo_next;
    logic signed [TOT_W-1:0]  total;
    logic signed [ACC_W-1:0]  angle;
    logic                     sum_ready;

    logic                     out_v_reg;
    logic [HEAD_W-1:0]        head_reg;
    logic [HEAD_W-1:0]        head_next;
    logic [QUO_W-1:0]         rem1;
    logic [QUO_W-1:0]         rem2;
    logic                     out_ready_int;

    logic signed [VEC_W-1:0]  xw;
    logic signed [VEC_W-1:0]  yw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg <= DECL_RESET;
        end
        else if (cfg_wr_en)
        begin
            decl_reg <= cfg_wr_data;
        end
    end

    // quadrant pre-rotation
    assign xw = VEC_W'(sample.x_axis) <<< PRE_SHIFT;
    assign yw = VEC_W'(sample.y_axis) <<< PRE_SHIFT;

    always_comb
    begin
        pre_next.zero = (sample.x_axis == '0) && (sample.y_axis == '0);
        pre_next.x    = xw;
        pre_next.y    = yw;
        pre_next.acc  = '0;
        if (xw[VEC_W-1])
        begin
            if (!yw[VEC_W-1])
            begin
                pre_next.x   = yw;
                pre_next.y   = -xw;
                pre_next.acc = ANGLE_90;
            end
            else
            begin
                pre_next.x   = -yw;
                pre_next.y   = xw;
                pre_next.acc = -ANGLE_90;
            end
        end
    end

    assign pre_ready    = !pre_v_reg || stg_ready[0];
    assign sample.ready = pre_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_v_reg <= 1'b0;
        end
        else if (pre_ready)
        begin
            pre_v_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pre_ready && sample.valid)
        begin
            pre_reg <= pre_next;
        end
    end

    assign stg_valid[0] = pre_v_reg;
    assign stg_vec[0]   = pre_reg;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_stage
            chc_cordic_stage #(
                .IDX (gi)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (stg_valid[gi]),
                .in_ready  (stg_ready[gi]),
                .in_vec    (stg_vec[gi]),
                .out_valid (stg_valid[gi+1]),
                .out_ready (stg_ready[gi+1]),
                .out_vec   (stg_vec[gi+1])
            );
        end
    endgenerate

    assign stg_ready[N] = sum_ready;

    // declination add, rounding and bias
    assign angle    = stg_vec[N].zero ? '0 : stg_vec[N].acc;
    assign total    = TOT_W'(angle) + (TOT_W'(decl_reg) <<< UNIT_SHIFT) + BIAS_ROUND;
    assign quo_next = total[UNIT_SHIFT +: QUO_W];

    assign sum_ready = !sum_v_reg || out_ready_int;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_v_reg <= 1'b0;
        end
        else if (sum_ready)
        begin
            sum_v_reg <= stg_valid[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_ready && stg_valid[N])
        begin
            quo_reg <= quo_next;
        end
    end

    // wrap into one full turn
    assign rem1      = (quo_reg >= TWO_TURNS) ? (quo_reg - TWO_TURNS) : quo_reg;
    assign rem2      = (rem1 >= FULL_TURN) ? (rem1 - FULL_TURN) : rem1;
    assign head_next = rem2[HEAD_W-1:0];

    assign out_ready_int = !out_v_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_ready_int)
        begin
            out_v_reg <= sum_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready_int && sum_v_reg)
        begin
            head_reg <= head_next;
        end
    end

    assign result.valid   = out_v_reg;
    assign result.heading = head_reg;

`ifndef NO_ASSERTIONS
    a_pre_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        pre_v_reg |-> !pre_reg.x[VEC_W-1])
        else $error("pre-rotated x is negative");

    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        sum_v_reg |-> (quo_reg < QUO_W'(4 * 23040)))
        else $error("rounded sum outside wrap range");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> (QUO_W'(head_reg) < FULL_TURN))
        else $error("heading not below a full turn");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !pre_v_reg |-> sample.ready)
        else $error("empty entry stage refuses a transaction");
`endif
endmodule

>>> rtl/chc_cordic_stage.sv
// One vectoring CORDIC micro-rotation stage with its own valid/ready register.
module chc_cordic_stage #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  chc_pkg::chc_vec_t in_vec,
    output logic              out_valid,
    input  logic              out_ready,
    output chc_pkg::chc_vec_t out_vec
);
    import chc_pkg::*;

    localparam logic signed [ACC_W-1:0] ATAN_I = chc_atan(IDX);

    logic                    valid_reg;
    chc_vec_t                vec_reg;
    chc_vec_t                vec_next;
    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;

    assign xs = in_vec.x;
    assign ys = in_vec.y;
    assign dx = ys >>> IDX;
    assign dy = xs >>> IDX;

    always_comb
    begin
        vec_next      = in_vec;
        if (!ys[VEC_W-1])
        begin
            vec_next.x   = xs + dx;
            vec_next.y   = ys - dy;
            vec_next.acc = in_vec.acc + ATAN_I;
        end
        else
        begin
            vec_next.x   = xs - dx;
            vec_next.y   = ys + dy;
            vec_next.acc = in_vec.acc - ATAN_I;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
endmodule

>>> bench/testbench.sv
// Testbench for compass_heading_from_xy: directed and random sample streams checked against a heading model.
`timescale 1ns / 1ps

module testbench;
    import chc_pkg::*;

    localparam int STAGES    = CORDIC_STAGES_DEF;
    localparam int RAND_ITEMS = 135;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
    } sample_t;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_PERIODIC, RX_HEAVY} rx_mode_t;

    localparam longint ATAN_DEG16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic signed [DECL_W-1:0] cfg_wr_data;

    chc_sample_if  smp ();
    chc_heading_if res ();

    compass_heading_from_xy #(.CORDIC_STAGES(STAGES)) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample      (smp),
        .result      (res)
    );

    sample_t                  sample_queue[$];
    logic [HEAD_W-1:0]        heading_expected[$];
    logic signed [DECL_W-1:0] decl_now;
    int unsigned              errors;
    int unsigned              samples_accepted;
    int unsigned              burst_left;
    int unsigned              gap_left;
    int unsigned              holdoff_left;
    int unsigned              next_hold_at;
    int unsigned              mode_left;
    rx_mode_t                 rx_mode;

    function automatic logic [HEAD_W-1:0] heading_of(input logic signed [AXIS_W-1:0] xa,
                                                     input logic signed [AXIS_W-1:0] ya,
                                                     input logic signed [DECL_W-1:0] decl);
        longint vx;
        longint vy;
        longint t;
        longint dx;
        longint dy;
        longint ang;
        longint total;
        int     n;
        vx  = xa;
        vy  = ya;
        ang = 0;
        n   = (STAGES > 24) ? 24 : STAGES;
        if (!(vx == 0 && vy == 0))
        begin
            vx = vx * 4096;
            vy = vy * 4096;
            if (vx < 0)
            begin
                if (vy >= 0)
                begin
                    t = vx; vx = vy; vy = -t;
                    ang = 90 * 65536;
                end
                else
                begin
                    t = vx; vx = -vy; vy = t;
                    ang = -90 * 65536;
                end
            end
            for (int i = 0; i < n; i++)
            begin
                dx = vy >>> i;
                dy = vx >>> i;
                if (vy >= 0)
                begin
                    vx  = vx + dx;
                    vy  = vy - dy;
                    ang = ang + ATAN_DEG16[i];
                end
                else
                begin
                    vx  = vx - dx;
                    vy  = vy + dy;
                    ang = ang - ATAN_DEG16[i];
                end
            end
        end
        total = ang + longint'(decl) * 1024 + 512 + longint'(2 * 23040 * 1024);
        return HEAD_W'((total >>> 10) % 23040);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task automatic load_sample(input int x, input int y);
        sample_t s;
        s.x = AXIS_W'(x);
        s.y = AXIS_W'(y);
        sample_queue.push_back(s);
    endtask

    task automatic load_random_sample();
        int pick [5];
        int x;
        int y;
        pick = '{-2048, -1, 0, 1, 2047};
        case ($urandom_range(0, 9))
            7:
            begin
                x = $urandom_range(0, 8) - 4;
                y = $urandom_range(0, 8) - 4;
            end
            8:
            begin
                x = $urandom_range(0, 4095) - 2048;
                y = $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1))
                begin
                    y = x;
                    x = $urandom_range(0, 2) - 1;
                end
            end
            9:
            begin
                x = pick[$urandom_range(0, 4)];
                y = pick[$urandom_range(0, 4)];
            end
            default:
            begin
                x = $urandom_range(0, 4095) - 2048;
                y = $urandom_range(0, 4095) - 2048;
            end
        endcase
        load_sample(x, y);
    endtask

    task automatic wait_idle();
        while (sample_queue.size() != 0 || smp.valid || heading_expected.size() != 0)
            @(negedge clk);
        repeat (STAGES + 6) @(negedge clk);
    endtask

    task automatic write_declination(input logic signed [DECL_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        decl_now = v;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("FAIL");
        $finish;
    end

    // sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        sample_t s;
        if (!rst_n)
        begin
            smp.valid  <= 1'b0;
            smp.x_axis <= '0;
            smp.y_axis <= '0;
            burst_left <= 1;
            gap_left   <= 0;
            samples_accepted <= 0;
        end
        else
        begin
            if (smp.valid && smp.ready)
            begin
                heading_expected.push_back(heading_of(smp.x_axis, smp.y_axis, decl_now));
                samples_accepted <= samples_accepted + 1;
            end
            if (!smp.valid || smp.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left  <= gap_left - 1;
                    smp.valid <= 1'b0;
                end
                else if (sample_queue.size() != 0)
                begin
                    s = sample_queue.pop_front();
                    smp.valid  <= 1'b1;
                    smp.x_axis <= s.x;
                    smp.y_axis <= s.y;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    smp.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off so the pipeline fills and backpressures the input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_left <= 0;
            next_hold_at <= 250;
        end
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
        else if (samples_accepted >= next_hold_at)
        begin
            holdoff_left <= 80;
            next_hold_at <= next_hold_at + 400;
        end
    end

    // receiver: stall pattern plus result check
    always @(posedge clk or negedge rst_n)
    begin
        logic [HEAD_W-1:0] want;
        logic              go;
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            rx_mode   <= RX_FREE;
            mode_left <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (heading_expected.size() == 0)
                    report_mismatch($sformatf("unexpected heading %0d", res.heading));
                else
                begin
                    want = heading_expected.pop_front();
                    if (res.heading !== want)
                        report_mismatch($sformatf("heading %0d, expected %0d", res.heading, want));
                end
            end
            if (mode_left == 0)
            begin
                rx_mode   <= rx_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(16, 96);
            end
            else
                mode_left <= mode_left - 1;
            case (rx_mode)
                RX_FREE:     go = 1'b1;
                RX_COIN:     go = 1'($urandom_range(0, 1));
                RX_PERIODIC: go = (mode_left % 4) != 0;
                default:     go = ($urandom_range(0, 4) == 0);
            endcase
            res.ready <= go && (holdoff_left == 0);
        end
    end

    initial
    begin
        logic signed [DECL_W-1:0] decl_plan [7];
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        smp.valid   = 1'b0;
        smp.x_axis  = '0;
        smp.y_axis  = '0;
        res.ready   = 1'b0;
        errors      = 0;
        decl_now    = DECL_RESET;
        decl_plan   = '{0, -16384, 16383, -11520, 11520, 0, 0};
        decl_plan[5] = DECL_W'($urandom_range(0, 32767));
        decl_plan[6] = DECL_W'(int'($urandom_range(0, 23040)) - 11520);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: zero vector, axes, extremes, every quadrant branch, near-zero angles
        load_sample(0, 0);
        load_sample(2047, 0);
        load_sample(-2048, 0);
        load_sample(0, 2047);
        load_sample(0, -2048);
        load_sample(2047, 2047);
        load_sample(-2048, -2048);
        load_sample(-2048, 2047);
        load_sample(2047, -2048);
        load_sample(-1, 0);
        load_sample(0, -1);
        load_sample(-1, -1);
        load_sample(1, 1);
        load_sample(2047, -1);
        load_sample(2047, 1);
        load_sample(-2048, 1);
        load_sample(-2048, -1);
        load_sample(-1, 2047);
        load_sample(1, -2048);
        for (int i = 0; i < RAND_ITEMS; i++)
            load_random_sample();

        for (int ph = 0; ph < 7; ph++)
        begin
            wait_idle();
            write_declination(decl_plan[ph]);
            @(negedge clk);
            load_sample(0, 0);
            load_sample(2047, 0);
            load_sample(-2048, -1);
            for (int i = 0; i < RAND_ITEMS; i++)
                load_random_sample();
        end

        wait_idle();
        repeat (STAGES + 8) @(negedge clk);
        if (errors == 0 && heading_expected.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
